### rtl/rfm_pkg.sv
`default_nettype none
package rfm_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int MAX_LOG2   = 10;
    localparam int ADDR_W     = 10;
    localparam int COMP_W     = 24;
    localparam int SAMPLE_W   = 16;
    localparam int TW_DEPTH   = MAX_POINTS / 2;
    localparam int TW_AW      = 9;
    localparam int WORD_W     = 2 * COMP_W;
    localparam int RAD_W      = 34;
    localparam int ROOT_W     = 17;
    localparam int SQRT_STEPS = 17;

    localparam logic [1:0] WR_LOAD   = 2'd0;
    localparam logic [1:0] WR_TOP    = 2'd1;
    localparam logic [1:0] WR_BOTTOM = 2'd2;

    typedef logic [31:0] t_tw_rom [TW_DEPTH];

    typedef struct packed {
        logic              cap_sample;
        logic [ADDR_W-1:0] rd_addr;
        logic              we;
        logic [ADDR_W-1:0] wr_addr;
        logic [1:0]        wr_sel;
        logic [TW_AW-1:0]  tw_addr;
        logic              cap_u;
        logic              mul_bf;
        logic              sum_bf;
        logic              mul_sq;
        logic              sum_sq;
        logic              sqrt_step;
        logic              out_go;
        logic              out_ok;
    } t_cmd;

    function automatic logic signed [15:0] f_q15(input longint v);
        longint t;
        t = v;
        if (t < 0) t = 0;
        if (t > (64'sd1 <<< 30)) t = 64'sd1 <<< 30;
        t = (t + 16384) >>> 15;
        if (t > 32767) t = 32767;
        return 16'(t);
    endfunction

    function automatic t_tw_rom f_build_rom();
        t_tw_rom rom;
        longint atn [30];
        longint x, y, z, dx, dy;
        longint turn;
        logic second;
        logic signed [15:0] c, s, cs, sn;
        atn = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                81, 41, 20, 10, 5, 3, 1};
        for (int k = 0; k < TW_DEPTH; k++) begin
            turn = longint'(k) * ((64'sd1 <<< 32) / MAX_POINTS);
            second = (turn >= (64'sd1 <<< 30));
            z = second ? turn - (64'sd1 <<< 30) : turn;
            x = 652032874;
            y = 0;
            for (int i = 0; i < 30; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - atn[i];
                end else begin
                    x = x + dx; y = y - dy; z = z + atn[i];
                end
            end
            c  = f_q15(x);
            s  = f_q15(y);
            cs = second ? -s : c;
            sn = second ? c : s;
            rom[k] = {cs, -sn};
        end
        return rom;
    endfunction

    localparam t_tw_rom TWIDDLE_ROM = f_build_rom();

endpackage
`default_nettype wire

### rtl/radix2_fft_magnitude.sv
// radix-2 fft magnitude spectrum, fixed point
// requests: start with busy low; i_operation 0 pushes i_sample, 1 reads bin i_bin_index
// a push writes one sample; the push that completes a frame of N = 2^log2 samples
// also runs the transform on one butterfly unit, N/2 * log2(N) butterflies;
// each butterfly runs to completion: two reads, multiply, sum, two writes
// on a read the square-root unit gives one result bit a cycle;
// a read with no finished frame or a bin above N/2 skips the square root, valid 0
// results: o_magnitude and o_valid_res for one cycle with o_strobe high;
// the receiver cannot stall, so a result is never held
// config: i_cfg_data written when i_cfg_valid and o_cfg_ready are high
// (ready while idle); it drops any partial or finished frame
// reset: size 1024, no frame, load count zero; buffer contents undefined
`default_nettype none
module radix2_fft_magnitude
    import rfm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_operation,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic [ADDR_W-1:0]   i_bin_index,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [3:0]          i_cfg_data,
    output logic [15:0]              o_magnitude,
    output logic                     o_valid_res,
    output logic                     o_strobe
);
    t_cmd cmd;

    rfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_operation(i_operation),
        .i_bin_index(i_bin_index),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_cfg_ready(o_cfg_ready),
        .busy       (busy),
        .o_cmd      (cmd)
    );

    rfm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_sample   (i_sample),
        .o_magnitude(o_magnitude),
        .o_valid_res(o_valid_res),
        .o_strobe   (o_strobe)
    );
endmodule
`default_nettype wire

### rtl/rfm_ram.sv
`default_nettype none
module rfm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/rfm_dp.sv
`default_nettype none
module rfm_dp
    import rfm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    output logic      [15:0]         o_magnitude,
    output logic                     o_valid_res,
    output logic                     o_strobe
);
    logic [WORD_W-1:0] rdata, wdata;
    logic [SAMPLE_W-1:0] r_sample;
    logic [31:0] r_w;
    logic signed [COMP_W-1:0] r_ure, r_uim;
    logic signed [39:0] r_m0, r_m1, r_m2, r_m3;
    logic signed [41:0] r_pr, r_pi;
    logic [47:0] r_sq0, r_sq1;
    logic [RAD_W-1:0] r_rad;
    logic [19:0] r_rem, rem_t, trial;
    logic [ROOT_W-1:0] r_root;
    logic [17:0] mag;
    logic signed [COMP_W-1:0] b_re, b_im;

    function automatic logic [COMP_W-1:0] f_half(input logic signed [COMP_W-1:0] u,
                                                 input logic signed [41:0] p);
        logic signed [41:0] t;
        logic signed [25:0] sh;
        t  = (42'(u) <<< 15) + p + 42'sd32768;
        sh = 26'(t >>> 16);
        if (sh > 26'sd8388607) return 24'h7fffff;
        if (sh < -26'sd8388608) return 24'h800000;
        return sh[COMP_W-1:0];
    endfunction

    rfm_ram #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_buf (
        .i_clk  (i_clk),
        .i_we   (i_cmd.we),
        .i_waddr(i_cmd.wr_addr),
        .i_wdata(wdata),
        .i_raddr(i_cmd.rd_addr),
        .o_rdata(rdata)
    );

    assign b_re = rdata[WORD_W-1:COMP_W];
    assign b_im = rdata[COMP_W-1:0];

    always_comb begin
        unique case (i_cmd.wr_sel)
            WR_LOAD:   wdata = {r_sample, 8'd0, {COMP_W{1'b0}}};
            WR_TOP:    wdata = {f_half(r_ure, r_pr), f_half(r_uim, r_pi)};
            WR_BOTTOM: wdata = {f_half(r_ure, -r_pr), f_half(r_uim, -r_pi)};
            default:   wdata = '0;
        endcase
    end

    assign rem_t = {r_rem[17:0], r_rad[RAD_W-1 -: 2]};
    assign trial = {1'b0, r_root, 2'b01};
    assign mag   = {1'b0, r_root} + 18'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_sample) r_sample <= i_sample;
        r_w <= TWIDDLE_ROM[i_cmd.tw_addr];
        if (i_cmd.cap_u) begin
            r_ure <= b_re;
            r_uim <= b_im;
        end
        if (i_cmd.mul_bf) begin
            r_m0 <= b_re * $signed(r_w[31:16]);
            r_m1 <= b_im * $signed(r_w[15:0]);
            r_m2 <= b_re * $signed(r_w[15:0]);
            r_m3 <= b_im * $signed(r_w[31:16]);
        end
        if (i_cmd.sum_bf) begin
            r_pr <= 42'(r_m0) - 42'(r_m1);
            r_pi <= 42'(r_m2) + 42'(r_m3);
        end
        if (i_cmd.mul_sq) begin
            r_sq0 <= unsigned'(48'(b_re * b_re));
            r_sq1 <= unsigned'(48'(b_im * b_im));
        end
        if (i_cmd.sum_sq) begin
            r_rad  <= RAD_W'(({1'b0, r_sq0} + {1'b0, r_sq1}) >> 14);
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (rem_t >= trial) begin
                r_rem  <= rem_t - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_t;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.out_go) begin
            o_valid_res <= i_cmd.out_ok;
            if (!i_cmd.out_ok) begin
                o_magnitude <= '0;
            end else if (mag[17:1] > 17'd32768) begin
                o_magnitude <= 16'h8000;
            end else begin
                o_magnitude <= mag[16:1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.out_go;
        end
    end
endmodule
`default_nettype wire

### rtl/rfm_ctrl.sv
`default_nettype none
module rfm_ctrl
    import rfm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic              i_operation,
    input  wire logic [ADDR_W-1:0] i_bin_index,
    input  wire logic              i_cfg_valid,
    input  wire logic [3:0]        i_cfg_data,
    output logic                   o_cfg_ready,
    output logic                   busy,
    output t_cmd                   o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0,  S_LOAD = 4'd1,  S_BF_RU = 4'd2,
                           S_BF_RB = 4'd3, S_BF_MUL = 4'd4, S_BF_SUM = 4'd5,
                           S_BF_WT = 4'd6, S_BF_WB = 4'd7, S_RD_A = 4'd8,
                           S_RD_W = 4'd9,  S_RD_M = 4'd10, S_RD_S = 4'd11,
                           S_SQRT = 4'd12, S_OUT = 4'd13;

    logic [3:0] r_state, n_state;
    logic [3:0] r_log2, bits;
    logic [ADDR_W:0] r_load, n_load, npts;
    logic r_ready, n_ready, r_ok, n_ok;
    logic [3:0] r_st, n_st;
    logic [TW_AW-1:0] r_bf, n_bf;
    logic [4:0] r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_bin, rev, pos, half, jj, grp, ua, ba;
    logic accept;

    assign bits = (r_log2 == 4'd0) ? 4'd1 :
                  (r_log2 > 4'(MAX_LOG2)) ? 4'(MAX_LOG2) : r_log2;
    assign npts = (ADDR_W+1)'(1) << bits;
    assign accept = start && !busy;
    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;

    always_comb begin
        for (int i = 0; i < ADDR_W; i++) rev[i] = r_load[ADDR_W-1-i];
    end
    assign pos  = rev >> (4'(MAX_LOG2) - bits);
    assign half = ADDR_W'(1) << (r_st - 4'd1);
    assign jj   = {1'b0, r_bf} & (half - ADDR_W'(1));
    assign grp  = {1'b0, r_bf} >> (r_st - 4'd1);
    assign ua   = (grp << r_st) | jj;
    assign ba   = ua | half;

    always_comb begin
        n_state = r_state;
        n_load  = r_load;
        n_ready = r_ready;
        n_ok    = r_ok;
        n_st    = r_st;
        n_bf    = r_bf;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.wr_sel  = WR_LOAD;
        o_cmd.tw_addr = TW_AW'(jj << (4'(MAX_LOG2) - r_st));
        o_cmd.rd_addr = ua;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.cap_sample = 1'b1;
                    if (i_operation) begin
                        n_ok    = r_ready && ({1'b0, i_bin_index} <= (npts >> 1));
                        n_state = S_RD_A;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.we      = 1'b1;
                o_cmd.wr_addr = pos;
                if (r_load == '0) n_ready = 1'b0;
                if (r_load + 1'b1 == npts) begin
                    n_load  = '0;
                    n_st    = 4'd1;
                    n_bf    = '0;
                    n_state = S_BF_RU;
                end else begin
                    n_load  = r_load + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_BF_RU: n_state = S_BF_RB;
            S_BF_RB: begin
                o_cmd.rd_addr = ba;
                o_cmd.cap_u   = 1'b1;
                n_state       = S_BF_MUL;
            end
            S_BF_MUL: begin
                o_cmd.mul_bf = 1'b1;
                n_state      = S_BF_SUM;
            end
            S_BF_SUM: begin
                o_cmd.sum_bf = 1'b1;
                n_state      = S_BF_WT;
            end
            S_BF_WT: begin
                o_cmd.we      = 1'b1;
                o_cmd.wr_sel  = WR_TOP;
                o_cmd.wr_addr = ua;
                n_state       = S_BF_WB;
            end
            S_BF_WB: begin
                o_cmd.we      = 1'b1;
                o_cmd.wr_sel  = WR_BOTTOM;
                o_cmd.wr_addr = ba;
                n_state       = S_BF_RU;
                if ({2'b0, r_bf} == (npts >> 1) - 1'b1) begin
                    n_bf = '0;
                    if (r_st == bits) begin
                        n_ready = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_st = r_st + 4'd1;
                    end
                end else begin
                    n_bf = r_bf + 1'b1;
                end
            end
            S_RD_A: begin
                o_cmd.rd_addr = r_bin;
                n_state = r_ok ? S_RD_W : S_OUT;
            end
            S_RD_W: begin
                o_cmd.rd_addr = r_bin;
                n_state = S_RD_M;
            end
            S_RD_M: begin
                o_cmd.mul_sq = 1'b1;
                n_state      = S_RD_S;
            end
            S_RD_S: begin
                o_cmd.sum_sq = 1'b1;
                n_cnt        = '0;
                n_state      = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'(SQRT_STEPS - 1)) n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.out_go = 1'b1;
                o_cmd.out_ok = r_ok;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_valid && o_cfg_ready) begin
            n_load  = '0;
            n_ready = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_log2  <= 4'(MAX_LOG2);
            r_load  <= '0;
            r_ready <= 1'b0;
            r_ok    <= 1'b0;
            r_st    <= 4'd1;
            r_bf    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_load  <= n_load;
            r_ready <= n_ready;
            r_ok    <= n_ok;
            r_st    <= n_st;
            r_bf    <= n_bf;
            r_cnt   <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) r_log2 <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_bin <= i_bin_index;
    end
endmodule
`default_nettype wire
